/* hdl/c2s_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared widths, constants and types of the cube-to-sphere vertex mapper.
// ----------------------------------------------------------------------------
package c2s_pkg;

  localparam int unsigned CoordW   = 8;
  localparam int unsigned OutW     = 16;
  localparam int unsigned FracBits = 15;

  localparam int unsigned SqW    = 2 * CoordW;        // d^2, n^2
  localparam int unsigned SumW   = SqW + 1;           // a^2 + b^2
  localparam int unsigned QuadW  = 4 * CoordW;        // d^4, a^2 b^2
  localparam int unsigned XW     = SqW + SumW;        // d^2 (a^2 + b^2)
  localparam int unsigned DenW   = QuadW + 3;         // 6 d^4
  localparam int unsigned FW     = DenW + 2;          // signed working width of F
  localparam int unsigned QuotW  = 2 * FracBits + 1;  // F * 2^30 / den
  localparam int unsigned RootW  = FracBits + 1;      // square root of the quotient
  localparam int unsigned ProdW  = CoordW + RootW;    // |n| * s
  localparam int unsigned ScNumW = ProdW + 2;         // 2 |n| s + d
  localparam int unsigned ScDivW = CoordW + 1;        // 2 d

  localparam logic [CoordW-1:0] GridReset = CoordW'(16);
  localparam logic [OutW-1:0]   MagOne    = OutW'(1 << FracBits);
  localparam logic [OutW-1:0]   MagLim    = OutW'((1 << FracBits) - 1);
  localparam logic [QuotW-1:0]  QuotMin   = QuotW'((64'd1 << (2 * FracBits)) / 3);

  typedef struct packed {
    logic              neg;
    logic [CoordW-1:0] absn;
    logic [CoordW-1:0] divs;
  } side_t;

  typedef struct packed {
    logic [DenW-1:0] f;
    logic [DenW-1:0] den;
    side_t           side;
  } axis_t;

  typedef struct packed {
    logic signed [OutW-1:0] sphere_x;
    logic signed [OutW-1:0] sphere_y;
    logic signed [OutW-1:0] sphere_z;
  } res_t;

endpackage

/* hdl/c2s_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s interfaces
// Valid/ready channels for configuration, lattice points and sphere points.
// ----------------------------------------------------------------------------
interface c2s_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [c2s_pkg::CoordW-1:0]    grid_divisions;
  modport source (output valid, output grid_divisions, input ready);
  modport sink (input valid, input grid_divisions, output ready);
endinterface

interface c2s_vtx_if;
  logic                          valid;
  logic                          ready;
  logic [c2s_pkg::CoordW-1:0]    grid_x;
  logic [c2s_pkg::CoordW-1:0]    grid_y;
  logic [c2s_pkg::CoordW-1:0]    grid_z;
  modport source (output valid, output grid_x, output grid_y, output grid_z, input ready);
  modport sink (input valid, input grid_x, input grid_y, input grid_z, output ready);
endinterface

interface c2s_sph_if;
  logic                          valid;
  logic                          ready;
  logic signed [c2s_pkg::OutW-1:0] sphere_x;
  logic signed [c2s_pkg::OutW-1:0] sphere_y;
  logic signed [c2s_pkg::OutW-1:0] sphere_z;
  modport source (output valid, output sphere_x, output sphere_y, output sphere_z,
                  input ready);
  modport sink (input valid, input sphere_x, input sphere_y, input sphere_z,
                output ready);
endinterface

/* hdl/cube_to_sphere_vertex_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_to_sphere_vertex_map
// Maps cube lattice points onto the unit sphere in signed Q1.15.
// ----------------------------------------------------------------------------
//   channel  dir  payload                          accepted when
//   cfg_i    in   grid_divisions [7:0]             valid & ready (always ready)
//   vtx_i    in   grid_x, grid_y, grid_z [7:0]     valid & ready
//   sph_o    out  sphere_x, sphere_y, sphere_z     valid & ready
//
// One request per cycle is taken while the skid stage is empty; each result
// passes the bit-per-stage quotient, square-root and scaling pipelines.
// Reset clears all valid bits and loads 16 subdivisions.
// A stalled output fills the skid stage, which stops the whole pipeline and
// drops ready on the input while it is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module cube_to_sphere_vertex_map (
  input  logic        clk_i,
  input  logic        rst_ni,
  c2s_cfg_if.sink     cfg_i,
  c2s_vtx_if.sink     vtx_i,
  c2s_sph_if.source   sph_o
);
  import c2s_pkg::*;

  logic [CoordW-1:0]      divs_q;
  logic                   en;
  logic                   prep_valid;
  axis_t                  axis [3];
  logic                   lane_valid [3];
  logic signed [OutW-1:0] lane_val [3];
  res_t                   lane_res;
  res_t                   out_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divs_q <= GridReset;
    end else if (cfg_i.valid) begin
      divs_q <= cfg_i.grid_divisions;
    end
  end

  assign vtx_i.ready = en;

  c2s_prep u_prep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (vtx_i.valid),
    .grid_x_i (vtx_i.grid_x),
    .grid_y_i (vtx_i.grid_y),
    .grid_z_i (vtx_i.grid_z),
    .divs_i   (divs_q),
    .valid_o  (prep_valid),
    .axis_o   (axis)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    c2s_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (prep_valid),
      .axis_i   (axis[i]),
      .valid_o  (lane_valid[i]),
      .sphere_o (lane_val[i])
    );
  end

  assign lane_res.sphere_x = lane_val[0];
  assign lane_res.sphere_y = lane_val[1];
  assign lane_res.sphere_z = lane_val[2];

  c2s_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lane_valid[0]),
    .data_i  (lane_res),
    .ready_i (sph_o.ready),
    .en_o    (en),
    .valid_o (sph_o.valid),
    .data_o  (out_data)
  );

  assign sph_o.sphere_x = out_data.sphere_x;
  assign sph_o.sphere_y = out_data.sphere_y;
  assign sph_o.sphere_z = out_data.sphere_z;

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lane_valid[0] == lane_valid[1]) && (lane_valid[1] == lane_valid[2]))
    else $error("cube_to_sphere_vertex_map: axis lanes out of step");

  a_ready_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!vtx_i.ready && !sph_o.ready) |=> !vtx_i.ready)
    else $error("cube_to_sphere_vertex_map: input reopened while output stalled");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid |=> (divs_q == $past(cfg_i.grid_divisions)))
    else $error("cube_to_sphere_vertex_map: register write lost");

endmodule

/* hdl/c2s_prep.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_prep
// Four-stage front end: clamps and centers the coordinates, then forms the
// radicand numerator F and denominator 6 d^4 for each axis.
// ----------------------------------------------------------------------------
module c2s_prep (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [c2s_pkg::CoordW-1:0] grid_x_i,
  input  logic [c2s_pkg::CoordW-1:0] grid_y_i,
  input  logic [c2s_pkg::CoordW-1:0] grid_z_i,
  input  logic [c2s_pkg::CoordW-1:0] divs_i,
  output logic                       valid_o,
  output c2s_pkg::axis_t             axis_o [3]
);
  import c2s_pkg::*;

  logic [3:0] vld_q;

  logic [CoordW-1:0]        p1_div_q;
  logic [2:0][CoordW-1:0]   p1_absn_q;
  logic [2:0]               p1_neg_q;

  logic [SqW-1:0]           p2_dsq_q;
  logic [2:0][SqW-1:0]      p2_sq_q;
  logic [CoordW-1:0]        p2_div_q;
  logic [2:0][CoordW-1:0]   p2_absn_q;
  logic [2:0]               p2_neg_q;

  logic [QuadW-1:0]         p3_quad_q;
  logic [2:0][XW-1:0]       p3_x_q;
  logic [2:0][QuadW-1:0]    p3_y_q;
  logic [CoordW-1:0]        p3_div_q;
  logic [2:0][CoordW-1:0]   p3_absn_q;
  logic [2:0]               p3_neg_q;

  logic [CoordW-1:0]        p1_div_d;
  logic [2:0][CoordW-1:0]   p1_absn_d;
  logic [2:0]               p1_neg_d;
  logic [2:0][XW-1:0]       p3_x_d;
  logic [2:0][QuadW-1:0]    p3_y_d;
  axis_t                    axis_d [3];

  // Stage 1: a zero register value counts as one subdivision.
  always_comb begin
    logic [2:0][CoordW-1:0] coord;
    logic [CoordW-1:0]      c;
    logic [CoordW+1:0]      nv;
    logic [CoordW+1:0]      mag;
    coord    = {grid_z_i, grid_y_i, grid_x_i};
    p1_div_d = (divs_i == '0) ? CoordW'(1) : divs_i;
    for (int i = 0; i < 3; i++) begin
      c            = (coord[i] > p1_div_d) ? p1_div_d : coord[i];
      nv           = {1'b0, c, 1'b0} - {2'b00, p1_div_d};
      mag          = nv[CoordW+1] ? (~nv + (CoordW+2)'(1)) : nv;
      p1_neg_d[i]  = nv[CoordW+1];
      p1_absn_d[i] = mag[CoordW-1:0];
    end
  end

  // Stage 3 products; each axis uses the squares of the other two.
  always_comb begin
    int oa;
    int ob;
    for (int i = 0; i < 3; i++) begin
      oa        = (i == 0) ? 1 : 0;
      ob        = (i == 2) ? 1 : 2;
      p3_x_d[i] = XW'(p2_dsq_q) * (XW'(p2_sq_q[oa]) + XW'(p2_sq_q[ob]));
      p3_y_d[i] = QuadW'(p2_sq_q[oa]) * QuadW'(p2_sq_q[ob]);
    end
  end

  // Stage 4: F = 6d^4 - 3d^2(a^2 + b^2) + 2a^2 b^2, held within [0, den].
  always_comb begin
    logic [DenW-1:0] den;
    logic [FW-1:0]   fs;
    den = (DenW'(p3_quad_q) << 2) + (DenW'(p3_quad_q) << 1);
    for (int i = 0; i < 3; i++) begin
      fs = {2'b00, den} + (FW'(p3_y_q[i]) << 1) - (FW'(p3_x_q[i]) << 1) - FW'(p3_x_q[i]);
      if (fs[FW-1]) begin
        axis_d[i].f = '0;
      end else if (fs[FW-2:0] > {1'b0, den}) begin
        axis_d[i].f = den;
      end else begin
        axis_d[i].f = fs[DenW-1:0];
      end
      axis_d[i].den       = den;
      axis_d[i].side.neg  = p3_neg_q[i];
      axis_d[i].side.absn = p3_absn_q[i];
      axis_d[i].side.divs = p3_div_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_div_q  <= p1_div_d;
      p1_absn_q <= p1_absn_d;
      p1_neg_q  <= p1_neg_d;

      p2_dsq_q  <= SqW'(p1_div_q) * SqW'(p1_div_q);
      for (int i = 0; i < 3; i++) begin
        p2_sq_q[i] <= SqW'(p1_absn_q[i]) * SqW'(p1_absn_q[i]);
      end
      p2_div_q  <= p1_div_q;
      p2_absn_q <= p1_absn_q;
      p2_neg_q  <= p1_neg_q;

      p3_quad_q <= QuadW'(p2_dsq_q) * QuadW'(p2_dsq_q);
      p3_x_q    <= p3_x_d;
      p3_y_q    <= p3_y_d;
      p3_div_q  <= p2_div_q;
      p3_absn_q <= p2_absn_q;
      p3_neg_q  <= p2_neg_q;

      for (int i = 0; i < 3; i++) begin
        axis_o[i] <= axis_d[i];
      end
    end
  end

  assign valid_o = vld_q[3];

endmodule

/* hdl/c2s_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_lane
// One output axis: pipelined F*2^30/den divider, pipelined integer square
// root, scale by |n|/d with rounding, then saturation to Q1.15.
// ----------------------------------------------------------------------------
module c2s_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  c2s_pkg::axis_t                  axis_i,
  output logic                            valid_o,
  output logic signed [c2s_pkg::OutW-1:0] sphere_o
);
  import c2s_pkg::*;

  logic              qd_valid_q [QuotW];
  logic [DenW-1:0]   qd_rem_q   [QuotW];
  logic [QuotW-1:0]  qd_quo_q   [QuotW];
  logic [DenW-1:0]   qd_den_q   [QuotW];
  side_t             qd_side_q  [QuotW];

  logic              sq_valid_q [RootW];
  logic [QuotW-1:0]  sq_num_q   [RootW];
  logic [QuotW-1:0]  sq_res_q   [RootW];
  side_t             sq_side_q  [RootW];

  logic              mu_valid_q;
  logic [ScNumW-1:0] mu_num_q;
  side_t             mu_side_q;

  logic              sd_valid_q [RootW];
  logic [ScDivW-1:0] sd_rem_q   [RootW];
  logic [ScNumW-1:0] sd_num_q   [RootW];
  logic [RootW-1:0]  sd_quo_q   [RootW];
  side_t             sd_side_q  [RootW];

  logic              out_valid_q;
  logic [OutW-1:0]   out_q;
  logic [OutW-1:0]   out_d;

  // Restoring division, one quotient bit per stage. The first stage yields
  // the integer part, which is one only when F equals den.
  for (genvar k = 0; k < QuotW; k++) begin : g_qd
    logic             pv;
    logic [DenW:0]    tr;
    logic [QuotW-1:0] pq;
    logic [DenW-1:0]  pden;
    side_t            ps;
    logic             ge;
    if (k == 0) begin : g_first
      assign pv   = valid_i;
      assign tr   = {1'b0, axis_i.f};
      assign pq   = '0;
      assign pden = axis_i.den;
      assign ps   = axis_i.side;
    end else begin : g_next
      assign pv   = qd_valid_q[k-1];
      assign tr   = {qd_rem_q[k-1], 1'b0};
      assign pq   = qd_quo_q[k-1];
      assign pden = qd_den_q[k-1];
      assign ps   = qd_side_q[k-1];
    end
    assign ge = (tr >= {1'b0, pden});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        qd_valid_q[k] <= 1'b0;
      end else if (en_i) begin
        qd_valid_q[k] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qd_rem_q[k]  <= ge ? DenW'(tr - {1'b0, pden}) : tr[DenW-1:0];
        qd_quo_q[k]  <= {pq[QuotW-2:0], ge};
        qd_den_q[k]  <= pden;
        qd_side_q[k] <= ps;
      end
    end
  end

  // Digit-by-digit square root, one result bit per stage.
  for (genvar j = 0; j < RootW; j++) begin : g_sq
    localparam logic [QuotW-1:0] Bit = QuotW'(1) << (2 * (RootW - 1 - j));
    logic             pv;
    logic [QuotW-1:0] pnum;
    logic [QuotW-1:0] pres;
    side_t            ps;
    logic [QuotW:0]   trial;
    logic             ge;
    if (j == 0) begin : g_first
      assign pv   = qd_valid_q[QuotW-1];
      assign pnum = qd_quo_q[QuotW-1];
      assign pres = '0;
      assign ps   = qd_side_q[QuotW-1];
    end else begin : g_next
      assign pv   = sq_valid_q[j-1];
      assign pnum = sq_num_q[j-1];
      assign pres = sq_res_q[j-1];
      assign ps   = sq_side_q[j-1];
    end
    assign trial = {1'b0, pres} + {1'b0, Bit};
    assign ge    = ({1'b0, pnum} >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[j] <= 1'b0;
      end else if (en_i) begin
        sq_valid_q[j] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_num_q[j]  <= ge ? QuotW'({1'b0, pnum} - trial) : pnum;
        sq_res_q[j]  <= ge ? ((pres >> 1) + Bit) : (pres >> 1);
        sq_side_q[j] <= ps;
      end
    end
  end

  // 2|n|s + d, the numerator of the rounded scaling by |n|/d.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_valid_q <= 1'b0;
    end else if (en_i) begin
      mu_valid_q <= sq_valid_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mu_num_q  <= {ProdW'(sq_side_q[RootW-1].absn) *
                    ProdW'(sq_res_q[RootW-1][RootW-1:0]), 1'b0}
                   + ScNumW'(sq_side_q[RootW-1].divs);
      mu_side_q <= sq_side_q[RootW-1];
    end
  end

  // Division by 2d. The quotient never exceeds the root, so the bits above
  // the low RootW already form a partial remainder below 2d.
  for (genvar m = 0; m < RootW; m++) begin : g_sd
    logic              pv;
    logic [ScDivW-1:0] prem;
    logic [ScNumW-1:0] pnum;
    logic [RootW-1:0]  pq;
    side_t             ps;
    logic [ScDivW:0]   tr;
    logic [ScDivW-1:0] dv;
    logic              ge;
    if (m == 0) begin : g_first
      assign pv   = mu_valid_q;
      assign prem = mu_num_q[RootW+ScDivW-1:RootW];
      assign pnum = mu_num_q;
      assign pq   = '0;
      assign ps   = mu_side_q;
    end else begin : g_next
      assign pv   = sd_valid_q[m-1];
      assign prem = sd_rem_q[m-1];
      assign pnum = sd_num_q[m-1];
      assign pq   = sd_quo_q[m-1];
      assign ps   = sd_side_q[m-1];
    end
    assign dv = {ps.divs, 1'b0};
    assign tr = {prem, pnum[RootW-1-m]};
    assign ge = (tr >= {1'b0, dv});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sd_valid_q[m] <= 1'b0;
      end else if (en_i) begin
        sd_valid_q[m] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_rem_q[m]  <= ge ? ScDivW'(tr - {1'b0, dv}) : tr[ScDivW-1:0];
        sd_num_q[m]  <= pnum;
        sd_quo_q[m]  <= {pq[RootW-2:0], ge};
        sd_side_q[m] <= ps;
      end
    end
  end

  // Positive results stop just below +1.0; negative ones may reach -1.0.
  always_comb begin
    logic [OutW-1:0] mag;
    side_t           ls;
    ls  = sd_side_q[RootW-1];
    mag = OutW'(sd_quo_q[RootW-1]);
    if (!ls.neg && (mag > MagLim)) begin
      mag = MagLim;
    end
    if (mag > MagOne) begin
      mag = MagOne;
    end
    out_d = ls.neg ? OutW'(-mag) : mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= sd_valid_q[RootW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign sphere_o = $signed(out_q);

  // The radicand is never below one third, so the quotient has a floor.
  a_quot_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qd_valid_q[QuotW-1] |-> (qd_quo_q[QuotW-1] >= QuotMin))
    else $error("c2s_lane: radicand quotient below one third");

  a_root_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_valid_q[RootW-1] |-> (sq_res_q[RootW-1] <= QuotW'(MagOne)))
    else $error("c2s_lane: square root above one");

  a_scale_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sd_valid_q[RootW-1] |-> (sd_quo_q[RootW-1] <= MagOne))
    else $error("c2s_lane: scaled magnitude above one");

endmodule

/* hdl/c2s_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2s_out_reg
// Output register with a skid stage; its fill state throttles the pipeline.
// ----------------------------------------------------------------------------
module c2s_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  c2s_pkg::res_t data_i,
  input  logic          ready_i,
  output logic          en_o,
  output logic          valid_o,
  output c2s_pkg::res_t data_o
);
  import c2s_pkg::*;

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_data_q;
  res_t skid_data_q;
  logic take, arrive, load_new, load_skid, pop_skid;

  // The pipeline moves whenever the skid stage is empty, so ready toward
  // the source is a register and never waits on the sink.
  assign en_o      = !skid_valid_q;
  assign take      = out_valid_q & ready_i;
  assign arrive    = en_o & valid_i;
  assign load_new  = arrive & (!out_valid_q | take);
  assign load_skid = arrive & out_valid_q & !take;
  assign pop_skid  = !en_o & take;

  assign out_valid_d  = load_new | pop_skid | (out_valid_q & !take);
  assign skid_valid_d = load_skid | (skid_valid_q & !pop_skid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_new) begin
      out_data_q <= data_i;
    end else if (pop_skid) begin
      out_data_q <= skid_data_q;
    end
    if (load_skid) begin
      skid_data_q <= data_i;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("c2s_out_reg: skid holds a request ahead of the output");

  a_skid_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !ready_i) |=> (skid_valid_q && $stable(skid_data_q)))
    else $error("c2s_out_reg: skid request lost while stalled");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ready_i) |=> out_valid_q)
    else $error("c2s_out_reg: unaccepted result dropped");

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the cube-to-sphere vertex mapper against an exact integer predictor
// of the mapping, over several subdivision settings, with random source gaps
// and random sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import c2s_pkg::*;

  localparam int unsigned LatencyWait = 120;
  localparam int unsigned CycleLimit  = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  c2s_cfg_if cfg_if ();
  c2s_vtx_if vtx_if ();
  c2s_sph_if sph_if ();

  cube_to_sphere_vertex_map uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .vtx_i (vtx_if),
    .sph_o (sph_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  res_t        expected_points[$];
  logic [7:0]  divisions;
  int unsigned error_count = 0;
  int unsigned points_sent = 0;
  int unsigned points_checked = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  logic        stall_mode = 1'b0;

  // Exact floor square root of a 64-bit value.
  function automatic longint unsigned int_sqrt(longint unsigned num);
    longint unsigned root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > num) bit_v >>= 2;
    while (bit_v != 0) begin
      if (num >= root + bit_v) begin
        num = num - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root >>= 1;
      end
      bit_v >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] sphere_axis(longint n, longint na, longint nb,
                                                     longint d);
    longint d2, den, f, v;
    longint unsigned q, rem, s, mag;
    d2 = d * d;
    den = 6 * d2 * d2;
    f = den - 3 * d2 * (na * na + nb * nb) + 2 * na * na * nb * nb;
    if (f < 0) f = 0;
    if (f > den) f = den;
    q = f / den;
    rem = f % den;
    for (int i = 0; i < 2 * FracBits; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    s = int_sqrt(q);
    mag = ((n < 0 ? -n : n) * s * 2 + d) / (2 * d);
    if (n >= 0 && mag > MagLim) mag = MagLim;
    if (mag > MagOne) mag = MagOne;
    v = (n < 0) ? -longint'(mag) : longint'(mag);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic res_t map_to_sphere(logic [7:0] gx, logic [7:0] gy, logic [7:0] gz);
    longint d, nx, ny, nz;
    res_t r;
    d = (divisions == 0) ? 1 : divisions;
    nx = 2 * ((gx > d) ? d : gx) - d;
    ny = 2 * ((gy > d) ? d : gy) - d;
    nz = 2 * ((gz > d) ? d : gz) - d;
    r.sphere_x = sphere_axis(nx, ny, nz, d);
    r.sphere_y = sphere_axis(ny, nx, nz, d);
    r.sphere_z = sphere_axis(nz, nx, ny, d);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Sink: stalls in runs, switching between a calm and a busy pattern.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    sph_if.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    if (rst_ni && sph_if.valid && sph_if.ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result, x", sph_if.sphere_x, 0);
      end else begin
        res_t e;
        e = expected_points.pop_front();
        if (sph_if.sphere_x !== e.sphere_x) report_mismatch("sphere_x", sph_if.sphere_x, e.sphere_x);
        if (sph_if.sphere_y !== e.sphere_y) report_mismatch("sphere_y", sph_if.sphere_y, e.sphere_y);
        if (sph_if.sphere_z !== e.sphere_z) report_mismatch("sphere_z", sph_if.sphere_z, e.sphere_z);
        points_checked++;
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Sends one request in bursts; a gap lowers valid for a random number of cycles.
  task automatic send_point(logic [7:0] gx, logic [7:0] gy, logic [7:0] gz);
    if (burst_left == 0) begin
      int unsigned gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        vtx_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    vtx_if.valid <= 1'b1;
    vtx_if.grid_x <= gx;
    vtx_if.grid_y <= gy;
    vtx_if.grid_z <= gz;
    do @(posedge clk_i); while (!vtx_if.ready);
    expected_points.push_back(map_to_sphere(gx, gy, gz));
    points_sent++;
  endtask

  task automatic drain();
    vtx_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_points.size() != 0) @(posedge clk_i);
    repeat (LatencyWait) @(posedge clk_i);
  endtask

  task automatic write_divisions(logic [7:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.grid_divisions <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    divisions = value;
    @(posedge clk_i);
  endtask

  task automatic test_reset_divisions();
    send_point(0, 0, 0);
    send_point(16, 16, 16);
    send_point(8, 8, 8);
    send_point(16, 8, 8);
    send_point(0, 8, 8);
    send_point(255, 255, 255);
    drain();
  endtask

  // Extremes of every field, the zero and the largest division counts, clamping.
  task automatic test_directed();
    write_divisions(8'd0);
    send_point(0, 0, 1);
    send_point(1, 0, 0);
    send_point(200, 0, 0);
    drain();
    write_divisions(8'd255);
    send_point(255, 255, 255);
    send_point(0, 0, 0);
    send_point(255, 0, 128);
    send_point(127, 127, 127);
    send_point(128, 128, 128);
    send_point(8'hAA, 8'h55, 8'hF0);
    drain();
    write_divisions(8'd2);
    send_point(2, 1, 1);
    send_point(0, 1, 1);
    send_point(1, 1, 1);
    send_point(3, 99, 2);
    drain();
  endtask

  task automatic test_random(int unsigned count, logic [7:0] value);
    write_divisions(value);
    for (int unsigned i = 0; i < count; i++) begin
      int unsigned top;
      // Mostly points on the lattice, some beyond it to exercise clamping.
      top = ($urandom_range(0, 9) == 0) ? 255 : ((value == 0) ? 1 : value);
      send_point(8'($urandom_range(0, top)), 8'($urandom_range(0, top)),
                 8'($urandom_range(0, top)));
      // Hold off once so the pipeline empties completely mid-phase.
      if (i == count / 2) begin
        vtx_if.valid <= 1'b0;
        @(posedge clk_i);
        while (expected_points.size() != 0) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.grid_divisions = '0;
    vtx_if.valid = 1'b0;
    vtx_if.grid_x = '0;
    vtx_if.grid_y = '0;
    vtx_if.grid_z = '0;
    sph_if.ready = 1'b1;
    divisions = GridReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_divisions();
    test_directed();
    test_random(250, 8'd16);
    test_random(200, 8'($urandom_range(3, 254)));
    test_random(150, 8'd255);
    test_random(120, 8'd1);
    test_random(100, 8'($urandom_range(17, 100)));
    $display("Sent %0d lattice points, checked %0d sphere points", points_sent,
             points_checked);
    $display("Divisions covered: 0, 1, 2, 16, 255 and two random settings");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
